// File: rtl/crcfc_pkg.sv
package crcfc_pkg;

  localparam logic [7:0] START_BYTE = 8'h7e;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_HDR   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CRCLO = 3'd4;
  localparam logic [2:0] PH_CRCHI = 3'd5;

  typedef logic [15:0] crc_t;

  // 16-entry nibble table for polynomial 0x1021
  function automatic crc_t nib_tab(input logic [3:0] idx);
    crc_t v;
    unique case (idx)
      4'h0: v = 16'h0000;
      4'h1: v = 16'h1021;
      4'h2: v = 16'h2042;
      4'h3: v = 16'h3063;
      4'h4: v = 16'h4084;
      4'h5: v = 16'h50a5;
      4'h6: v = 16'h60c6;
      4'h7: v = 16'h70e7;
      4'h8: v = 16'h8108;
      4'h9: v = 16'h9129;
      4'ha: v = 16'ha14a;
      4'hb: v = 16'hb16b;
      4'hc: v = 16'hc18c;
      4'hd: v = 16'hd1ad;
      4'he: v = 16'he1ce;
      default: v = 16'hf1ef;
    endcase
    return v;
  endfunction

  function automatic crc_t crc_nibble(input crc_t crc, input logic [3:0] nib);
    crc_t sh;
    sh = {crc[11:0], 4'h0};
    return sh ^ nib_tab(crc[15:12] ^ nib);
  endfunction

  // high nibble first
  function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] b);
    crc_t mid;
    mid = crc_nibble(crc, b[7:4]);
    return crc_nibble(mid, b[3:0]);
  endfunction

endpackage

// File: rtl/crcfc_if.sv
interface crcfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface crcfc_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [7:0]  payload_length;
  logic [7:0]  header_byte;
  logic [15:0] crc_computed;
  logic [15:0] crc_received;

  modport source (output valid, output frame_ok, output payload_length,
                  output header_byte, output crc_computed, output crc_received,
                  input ready);
  modport sink   (input valid, input frame_ok, input payload_length,
                  input header_byte, input crc_computed, input crc_received,
                  output ready);
endinterface

// File: rtl/crc16_frame_checker_unit.sv
// CRC-16 (0x1021, init 0) frame checker.
// in_ch carries one stream byte per item. The block hunts for 0x7e, then
// takes a length byte, a header byte, that many payload bytes and a CRC
// sent low byte first. The CRC covers the payload bytes only.
// out_ch carries one verdict per frame, issued for the high CRC byte:
// frame_ok plus length, header, computed and received CRC.
// Throughput: one byte per cycle unless out_ch stalls a waiting verdict;
// the per-byte CRC update is two table steps between the input register
// and the state/result registers. The last CRC byte passes the input
// register, then the result register, where the verdict becomes valid.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to hunting with all frame state cleared.
// When out_ch stalls with a verdict waiting, the byte in the input register
// is held and in_ch.ready drops once that register is full; no item is lost.
module crc16_frame_checker_unit
  import crcfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  crcfc_in_if.sink    in_ch,
  crcfc_out_if.source out_ch
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r, in_byte_nxt;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] frame_len_r, frame_len_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] hdr_byte_r, hdr_byte_nxt;
  crc_t       crc_acc_r, crc_acc_nxt;
  logic [7:0] crc_low_r, crc_low_nxt;

  logic       out_vld_r, out_vld_nxt;
  logic       out_ok_r, out_ok_nxt;
  logic [7:0] out_len_r, out_len_nxt;
  logic [7:0] out_hdr_r, out_hdr_nxt;
  crc_t       out_crc_c_r, out_crc_c_nxt;
  crc_t       out_crc_rx_r, out_crc_rx_nxt;

  logic       advance;
  crc_t       rx_crc;
  crc_t       crc_upd;

  // process the held byte only when the result slot is free or draining
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  assign rx_crc  = {in_byte_r, crc_low_r};
  assign crc_upd = crc_byte(crc_acc_r, in_byte_r);

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_byte_nxt = in_byte_r;
    if (in_ch.valid && in_ch.ready) begin
      in_vld_nxt  = 1'b1;
      in_byte_nxt = in_ch.data_byte;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    frame_len_nxt  = frame_len_r;
    bytes_left_nxt = bytes_left_r;
    hdr_byte_nxt   = hdr_byte_r;
    crc_acc_nxt    = crc_acc_r;
    crc_low_nxt    = crc_low_r;

    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_ok_nxt     = out_ok_r;
    out_len_nxt    = out_len_r;
    out_hdr_nxt    = out_hdr_r;
    out_crc_c_nxt  = out_crc_c_r;
    out_crc_rx_nxt = out_crc_rx_r;

    if (advance) begin
      unique case (phase_r)
        PH_LEN: begin
          frame_len_nxt  = in_byte_r;
          bytes_left_nxt = in_byte_r;
          phase_nxt      = PH_HDR;
        end
        PH_HDR: begin
          hdr_byte_nxt = in_byte_r;
          crc_acc_nxt  = '0;
          phase_nxt    = (bytes_left_r == 8'd0) ? PH_CRCLO : PH_DATA;
        end
        PH_DATA: begin
          crc_acc_nxt    = crc_upd;
          bytes_left_nxt = bytes_left_r - 8'd1;
          if (bytes_left_r == 8'd1) begin
            phase_nxt = PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          crc_low_nxt = in_byte_r;
          phase_nxt   = PH_CRCHI;
        end
        PH_CRCHI: begin
          out_vld_nxt    = 1'b1;
          out_ok_nxt     = (crc_acc_r == rx_crc);
          out_len_nxt    = frame_len_r;
          out_hdr_nxt    = hdr_byte_r;
          out_crc_c_nxt  = crc_acc_r;
          out_crc_rx_nxt = rx_crc;
          phase_nxt      = PH_HUNT;
        end
        default: begin
          // hunting, and any unused code
          phase_nxt = (in_byte_r == START_BYTE) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      phase_r      <= PH_HUNT;
      frame_len_r  <= '0;
      bytes_left_r <= '0;
      hdr_byte_r   <= '0;
      crc_acc_r    <= '0;
      crc_low_r    <= '0;
    end else begin
      in_vld_r     <= in_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      phase_r      <= phase_nxt;
      frame_len_r  <= frame_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      hdr_byte_r   <= hdr_byte_nxt;
      crc_acc_r    <= crc_acc_nxt;
      crc_low_r    <= crc_low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r    <= in_byte_nxt;
    out_ok_r     <= out_ok_nxt;
    out_len_r    <= out_len_nxt;
    out_hdr_r    <= out_hdr_nxt;
    out_crc_c_r  <= out_crc_c_nxt;
    out_crc_rx_r <= out_crc_rx_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.frame_ok       = out_ok_r;
  assign out_ch.payload_length = out_len_r;
  assign out_ch.header_byte    = out_hdr_r;
  assign out_ch.crc_computed   = out_crc_c_r;
  assign out_ch.crc_received   = out_crc_rx_r;

endmodule
